>>> hw/rtl/ndefrsp_pkg.sv
`timescale 1ns / 1ps

package ndefrsp_pkg;

  // Parse phase; the data phases double as their byte kind code
  typedef enum logic [2:0] {
    PH_HEADER      = 3'd0,
    PH_TYPE_LEN    = 3'd1,
    PH_PAYLOAD_LEN = 3'd2,
    PH_ID_LEN      = 3'd3,
    PH_TYPE        = 3'd4,
    PH_ID          = 3'd5,
    PH_PAYLOAD     = 3'd6
  } phase_t;

  localparam logic [2:0] KIND_HEADER      = 3'd0;
  localparam logic [2:0] KIND_TYPE_LEN    = 3'd1;
  localparam logic [2:0] KIND_PAYLOAD_LEN = 3'd2;
  localparam logic [2:0] KIND_ID_LEN      = 3'd3;
  localparam logic [2:0] KIND_TYPE        = 3'd4;
  localparam logic [2:0] KIND_ID          = 3'd5;
  localparam logic [2:0] KIND_PAYLOAD     = 3'd6;
  localparam logic [2:0] KIND_IGNORED     = 3'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_TOO_MANY  = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // Header flag bit positions
  localparam int FLAG_MB_BIT = 7;
  localparam int FLAG_ME_BIT = 6;
  localparam int FLAG_SR_BIT = 4;
  localparam int FLAG_IL_BIT = 3;

  localparam logic [15:0] CAPACITY_RESET = 16'd1024;
  localparam logic [1:0]  REG_STORAGE_CAPACITY = 2'd0;

  typedef struct packed {
    logic [7:0] field_byte;
    logic [2:0] byte_kind;
    logic [3:0] record_index;
    logic [2:0] record_tnf;
    logic       record_end;
    logic       message_done;
    logic [1:0] status;
  } result_t;

endpackage

>>> hw/rtl/ndef_record_stream_parser_unit.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// input     in         in_valid/in_stall  data_byte, last_byte
// output    out        out_valid/out_stall field_byte, byte_kind, record_index,
//                                          record_tnf, record_end, message_done, status
// config    in         APB write/read     storage_capacity at byte address 0
//
// One item per cycle while the output is not stalled: each byte is parsed from the parse state
// registers into the result register, so results appear in the cycle after acceptance.
// The only stall path is a full result register that is itself stalled.
// Reset (synchronous) clears the parse state and sets storage_capacity to 1024.
// The last byte of a message returns the parse state to reset; the capacity stays.

module ndef_record_stream_parser_unit #(
  parameter int MAX_RECORDS    = 16,
  parameter int MAX_TYPE_BYTES = 32,
  parameter int MAX_ID_BYTES   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  field_byte,
  output logic [2:0]  byte_kind,
  output logic [3:0]  record_index,
  output logic [2:0]  record_tnf,
  output logic        record_end,
  output logic        message_done,
  output logic [1:0]  status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic                 accept;
  logic [15:0]          storage_capacity;
  ndefrsp_pkg::result_t res;
  ndefrsp_pkg::result_t result;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign pready   = 1'b1;
  assign prdata   = (paddr == ndefrsp_pkg::REG_STORAGE_CAPACITY) ?
                    {16'd0, storage_capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      storage_capacity <= ndefrsp_pkg::CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == ndefrsp_pkg::REG_STORAGE_CAPACITY)) begin
      storage_capacity <= pwdata[15:0];
    end
  end

  ndefrsp_parser #(
    .MAX_RECORDS    (MAX_RECORDS),
    .MAX_TYPE_BYTES (MAX_TYPE_BYTES),
    .MAX_ID_BYTES   (MAX_ID_BYTES)
  ) u_parser (
    .clk              (clk),
    .rst              (rst),
    .step             (accept),
    .data_byte        (data_byte),
    .last_byte        (last_byte),
    .storage_capacity (storage_capacity),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= res;
    end
  end

  assign field_byte   = result.field_byte;
  assign byte_kind    = result.byte_kind;
  assign record_index = result.record_index;
  assign record_tnf   = result.record_tnf;
  assign record_end   = result.record_end;
  assign message_done = result.message_done;
  assign status       = result.status;

  a_status_only_when_done : assert property (@(posedge clk) disable iff (rst)
    out_valid && !message_done |-> status == ndefrsp_pkg::ST_OK)
    else $error("status set on a byte that does not end the message");

  a_ignored_is_blank : assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_kind == ndefrsp_pkg::KIND_IGNORED) |->
      !record_end && (record_index == 4'd0) && (record_tnf == 3'd0))
    else $error("ignored item carries record information");

  a_end_on_data_kind : assert property (@(posedge clk) disable iff (rst)
    out_valid && record_end |->
      (byte_kind != ndefrsp_pkg::KIND_HEADER) && (byte_kind != ndefrsp_pkg::KIND_TYPE_LEN) &&
      (byte_kind != ndefrsp_pkg::KIND_IGNORED))
    else $error("record end marked on a header, type length or ignored item");

endmodule

>>> hw/rtl/ndefrsp_parser.sv
`timescale 1ns / 1ps

module ndefrsp_parser #(
  parameter int MAX_RECORDS    = 16,
  parameter int MAX_TYPE_BYTES = 32,
  parameter int MAX_ID_BYTES   = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 last_byte,
  input  logic [15:0]          storage_capacity,
  output ndefrsp_pkg::result_t res
);

  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  ndefrsp_pkg::phase_t phase, phase_next;
  logic [CNT_W-1:0] record_count, record_count_next;
  logic [7:0]  header_flags, header_flags_next;
  logic [7:0]  type_len, type_len_next;
  logic [7:0]  id_len, id_len_next;
  logic [15:0] payload_len, payload_len_next;
  logic        payload_big, payload_big_next;
  logic [1:0]  length_left, length_left_next;
  logic [15:0] field_left, field_left_next;
  logic [15:0] storage_used, storage_used_next;
  logic [1:0]  error_code, error_code_next;
  logic        error_latched, error_latched_next;
  logic        overflow_pending, overflow_pending_next;
  logic        end_seen, end_seen_next;

  logic        ld_go, nf_go, finish, ld_bad;
  logic [2:0]  nf_from;
  logic [16:0] need;
  logic [17:0] fill_sum;
  logic [15:0] field_dec;
  logic [2:0]  kind;
  logic [3:0]  idx;
  logic [2:0]  tnf;
  logic [1:0]  status;

  always_comb begin
    phase_next            = phase;
    record_count_next     = record_count;
    header_flags_next     = header_flags;
    type_len_next         = type_len;
    id_len_next           = id_len;
    payload_len_next      = payload_len;
    payload_big_next      = payload_big;
    length_left_next      = length_left;
    field_left_next       = field_left;
    storage_used_next     = storage_used;
    error_code_next       = error_code;
    error_latched_next    = error_latched;
    overflow_pending_next = overflow_pending;
    end_seen_next         = end_seen;
    ld_go   = 1'b0;
    nf_go   = 1'b0;
    finish  = 1'b0;
    ld_bad  = 1'b0;
    nf_from = ndefrsp_pkg::PH_TYPE;
    need     = '0;
    fill_sum = '0;
    kind   = ndefrsp_pkg::KIND_IGNORED;
    idx    = '0;
    tnf    = '0;
    status = ndefrsp_pkg::ST_OK;
    field_dec = (field_left != 16'd0) ? field_left - 16'd1 : 16'd0;

    if (!error_latched) begin
      if (phase == ndefrsp_pkg::PH_HEADER) begin
        if (record_count >= CNT_W'(MAX_RECORDS)) begin
          error_latched_next = 1'b1;
          error_code_next    = ndefrsp_pkg::ST_TOO_MANY;
        end else if ((data_byte[ndefrsp_pkg::FLAG_MB_BIT] != (record_count == '0)) ||
                     end_seen) begin
          error_latched_next = 1'b1;
          error_code_next    = ndefrsp_pkg::ST_MALFORMED;
        end else begin
          header_flags_next = data_byte;
          type_len_next     = '0;
          id_len_next       = '0;
          payload_len_next  = '0;
          payload_big_next  = 1'b0;
          length_left_next  = '0;
          field_left_next   = '0;
          kind              = ndefrsp_pkg::KIND_HEADER;
          phase_next        = ndefrsp_pkg::PH_TYPE_LEN;
        end
      end else begin
        kind = phase;
        case (phase)
          ndefrsp_pkg::PH_TYPE_LEN: begin
            type_len_next    = data_byte;
            phase_next       = ndefrsp_pkg::PH_PAYLOAD_LEN;
            length_left_next = header_flags[ndefrsp_pkg::FLAG_SR_BIT] ? 2'd0 : 2'd3;
          end
          ndefrsp_pkg::PH_PAYLOAD_LEN: begin
            // Only whether the length exceeds 16 bits matters beyond the low half
            payload_len_next = {payload_len[7:0], data_byte};
            payload_big_next = payload_big | (payload_len[15:8] != 8'd0);
            if (length_left != 2'd0) begin
              length_left_next = length_left - 2'd1;
            end else if (header_flags[ndefrsp_pkg::FLAG_IL_BIT]) begin
              phase_next = ndefrsp_pkg::PH_ID_LEN;
            end else begin
              ld_go = 1'b1;
            end
          end
          ndefrsp_pkg::PH_ID_LEN: begin
            id_len_next = data_byte;
            ld_go       = 1'b1;
          end
          default: begin
            field_left_next = field_dec;
            if (field_dec == 16'd0) begin
              nf_go   = 1'b1;
              nf_from = 3'(phase) + 3'd1;
            end
          end
        endcase

        // All lengths known: check limits, then reserve storage
        if (ld_go) begin
          ld_bad = (type_len_next > 8'(MAX_TYPE_BYTES)) ||
                   (id_len_next > 8'(MAX_ID_BYTES)) || payload_big_next;
          if (ld_bad) begin
            error_latched_next = 1'b1;
            error_code_next    = ndefrsp_pkg::ST_MALFORMED;
          end else begin
            need     = 17'(type_len_next) + 17'(id_len_next) + 17'(payload_len_next);
            fill_sum = 18'(need) + 18'(storage_used);
            if (fill_sum > 18'(storage_capacity)) begin
              overflow_pending_next = 1'b1;
            end else begin
              storage_used_next = fill_sum[15:0];
            end
            nf_go   = 1'b1;
            nf_from = ndefrsp_pkg::PH_TYPE;
          end
        end

        // Advance to the next non-empty data field, or close the record
        if (nf_go) begin
          if ((nf_from <= ndefrsp_pkg::PH_TYPE) && (type_len_next != 8'd0)) begin
            phase_next      = ndefrsp_pkg::PH_TYPE;
            field_left_next = 16'(type_len_next);
          end else if ((nf_from <= ndefrsp_pkg::PH_ID) && (id_len_next != 8'd0)) begin
            phase_next      = ndefrsp_pkg::PH_ID;
            field_left_next = 16'(id_len_next);
          end else if ((nf_from <= ndefrsp_pkg::PH_PAYLOAD) &&
                       (payload_len_next != 16'd0)) begin
            phase_next      = ndefrsp_pkg::PH_PAYLOAD;
            field_left_next = payload_len_next;
          end else begin
            finish = 1'b1;
          end
        end

        if (finish) begin
          record_count_next = record_count + CNT_W'(1);
          phase_next        = ndefrsp_pkg::PH_HEADER;
          if (overflow_pending_next) begin
            overflow_pending_next = 1'b0;
            error_latched_next    = 1'b1;
            error_code_next       = ndefrsp_pkg::ST_OVERFLOW;
          end else if (header_flags[ndefrsp_pkg::FLAG_ME_BIT]) begin
            end_seen_next = 1'b1;
            if (!last_byte) begin
              error_latched_next = 1'b1;
              error_code_next    = ndefrsp_pkg::ST_MALFORMED;
            end
          end
        end
      end

      if (kind != ndefrsp_pkg::KIND_IGNORED) begin
        idx = 4'(record_count);
        tnf = header_flags_next[2:0];
      end
    end

    if (last_byte) begin
      if (error_latched_next) begin
        status = error_code_next;
      end else if (overflow_pending_next || (phase_next != ndefrsp_pkg::PH_HEADER) ||
                   !end_seen_next) begin
        status = ndefrsp_pkg::ST_MALFORMED;
      end else begin
        status = ndefrsp_pkg::ST_OK;
      end
    end

    res.field_byte   = data_byte;
    res.byte_kind    = kind;
    res.record_index = idx;
    res.record_tnf   = tnf;
    res.record_end   = finish;
    res.message_done = last_byte;
    res.status       = status;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && last_byte)) begin
      // A message end returns the parse state to its reset values
      phase            <= ndefrsp_pkg::PH_HEADER;
      record_count     <= '0;
      header_flags     <= '0;
      type_len         <= '0;
      id_len           <= '0;
      payload_len      <= '0;
      payload_big      <= 1'b0;
      length_left      <= '0;
      field_left       <= '0;
      storage_used     <= '0;
      error_code       <= ndefrsp_pkg::ST_OK;
      error_latched    <= 1'b0;
      overflow_pending <= 1'b0;
      end_seen         <= 1'b0;
    end else if (step) begin
      phase            <= phase_next;
      record_count     <= record_count_next;
      header_flags     <= header_flags_next;
      type_len         <= type_len_next;
      id_len           <= id_len_next;
      payload_len      <= payload_len_next;
      payload_big      <= payload_big_next;
      length_left      <= length_left_next;
      field_left       <= field_left_next;
      storage_used     <= storage_used_next;
      error_code       <= error_code_next;
      error_latched    <= error_latched_next;
      overflow_pending <= overflow_pending_next;
      end_seen         <= end_seen_next;
    end
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ndefrsp_pkg::*;

  localparam int MAX_RECORDS    = 16;
  localparam int MAX_TYPE_BYTES = 32;
  localparam int MAX_ID_BYTES   = 32;
  localparam logic [31:0] PAYLOAD_MAX = 32'd65535;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  typedef enum int {
    FLAW_NONE, FLAW_TRUNCATE, FLAW_EARLY_ME, FLAW_NO_ME, FLAW_BAD_MB,
    FLAW_MANY, FLAW_LIMIT, FLAW_NOISE
  } flaw_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  field_byte;
  logic [2:0]  byte_kind;
  logic [3:0]  record_index;
  logic [2:0]  record_tnf;
  logic        record_end;
  logic        message_done;
  logic [1:0]  status;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [1:0]  paddr = 2'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  byte_item_t  byte_queue[$];
  result_t     expected_tags[$];
  byte_item_t  next_item;
  result_t     want_tag;
  logic        byte_taken = 1'b0;
  int unsigned queued_count = 0;
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        pressure_go = 1'b0;
  logic        long_hold = 1'b0;

  // Parser state as the block should hold it
  phase_t      cur_phase;
  logic [4:0]  rec_count;
  logic [7:0]  hdr_flags;
  logic [7:0]  type_len;
  logic [7:0]  id_len;
  logic [31:0] payload_len;
  logic [1:0]  len_bytes_left;
  logic [15:0] field_left;
  logic [16:0] stored_bytes;
  logic [1:0]  err_code;
  logic        err_latched;
  logic        ovf_pending;
  logic        me_record_done;
  logic [15:0] storage_limit;

  ndef_record_stream_parser_unit #(
    .MAX_RECORDS   (MAX_RECORDS),
    .MAX_TYPE_BYTES(MAX_TYPE_BYTES),
    .MAX_ID_BYTES  (MAX_ID_BYTES)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .last_byte   (last_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .field_byte  (field_byte),
    .byte_kind   (byte_kind),
    .record_index(record_index),
    .record_tnf  (record_tnf),
    .record_end  (record_end),
    .message_done(message_done),
    .status      (status),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void raise_error(input logic [1:0] code);
    if (!err_latched) begin
      err_latched = 1'b1;
      err_code = code;
    end
  endfunction

  function automatic void clear_parse();
    cur_phase = PH_HEADER;
    rec_count = '0;
    hdr_flags = '0;
    type_len = '0;
    id_len = '0;
    payload_len = '0;
    len_bytes_left = '0;
    field_left = '0;
    stored_bytes = '0;
    err_code = ST_OK;
    err_latched = 1'b0;
    ovf_pending = 1'b0;
    me_record_done = 1'b0;
  endfunction

  // Step to the next non-empty data field at or after from_ph, else close the record
  function automatic logic enter_field(input logic [2:0] from_ph, input logic lst);
    if (from_ph <= PH_TYPE && type_len != 0) begin
      cur_phase = PH_TYPE;
      field_left = 16'(type_len);
      return 1'b0;
    end
    if (from_ph <= PH_ID && id_len != 0) begin
      cur_phase = PH_ID;
      field_left = 16'(id_len);
      return 1'b0;
    end
    if (from_ph <= PH_PAYLOAD && payload_len != 0) begin
      cur_phase = PH_PAYLOAD;
      field_left = payload_len[15:0];
      return 1'b0;
    end
    rec_count++;
    cur_phase = PH_HEADER;
    if (ovf_pending) begin
      ovf_pending = 1'b0;
      raise_error(ST_OVERFLOW);
    end else if (hdr_flags[FLAG_ME_BIT]) begin
      me_record_done = 1'b1;
      if (!lst) raise_error(ST_MALFORMED);
    end
    return 1'b1;
  endfunction

  function automatic logic close_lengths(input logic lst);
    int unsigned need;
    if (type_len > MAX_TYPE_BYTES || id_len > MAX_ID_BYTES || payload_len > PAYLOAD_MAX) begin
      raise_error(ST_MALFORMED);
      return 1'b0;
    end
    need = int'(type_len) + int'(id_len) + payload_len;
    if (int'(stored_bytes) > int'(storage_limit) ||
        need > int'(storage_limit) - int'(stored_bytes))
      ovf_pending = 1'b1;
    else
      stored_bytes = 17'(int'(stored_bytes) + need);
    return enter_field(PH_TYPE, lst);
  endfunction

  function automatic result_t parse_byte(input logic [7:0] b, input logic lst);
    result_t r;
    logic rend;
    r = '0;
    rend = 1'b0;
    r.field_byte = b;
    r.byte_kind = KIND_IGNORED;
    if (!err_latched) begin
      if (cur_phase == PH_HEADER) begin
        if (rec_count >= MAX_RECORDS)
          raise_error(ST_TOO_MANY);
        else if (b[FLAG_MB_BIT] != (rec_count == 0) || me_record_done)
          raise_error(ST_MALFORMED);
        else begin
          hdr_flags = b;
          type_len = '0;
          id_len = '0;
          payload_len = '0;
          len_bytes_left = '0;
          field_left = '0;
          r.byte_kind = KIND_HEADER;
          cur_phase = PH_TYPE_LEN;
        end
      end else begin
        r.byte_kind = cur_phase;
        case (cur_phase)
          PH_TYPE_LEN: begin
            type_len = b;
            cur_phase = PH_PAYLOAD_LEN;
            len_bytes_left = hdr_flags[FLAG_SR_BIT] ? 2'd0 : 2'd3;
          end
          PH_PAYLOAD_LEN: begin
            payload_len = {payload_len[23:0], b};
            if (len_bytes_left != 0)
              len_bytes_left--;
            else if (hdr_flags[FLAG_IL_BIT])
              cur_phase = PH_ID_LEN;
            else
              rend = close_lengths(lst);
          end
          PH_ID_LEN: begin
            id_len = b;
            rend = close_lengths(lst);
          end
          default: begin
            if (field_left != 0) field_left--;
            if (field_left == 0) rend = enter_field(cur_phase + 3'd1, lst);
          end
        endcase
      end
      if (r.byte_kind != KIND_IGNORED) begin
        r.record_index = 4'(rec_count - rend);
        r.record_tnf = hdr_flags[2:0];
      end
    end
    r.record_end = rend;
    r.message_done = lst;
    if (lst) begin
      if (err_latched)
        r.status = err_code;
      else if (ovf_pending || cur_phase != PH_HEADER || !me_record_done)
        r.status = ST_MALFORMED;
      else
        r.status = ST_OK;
      clear_parse();
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 100) $display("%0t ns: mismatch, %s", $time, msg);
  endtask

  task automatic compare_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s: got %0h, expected %0h", what, got, want));
  endtask

  task automatic apb_write(input logic [15:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_STORAGE_CAPACITY;  // register 0 sits at byte address 0
    pwdata <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    storage_limit = value;
  endtask

  task automatic queue_message(input logic [7:0] msg[$]);
    byte_item_t it;
    foreach (msg[i]) begin
      it.data = msg[i];
      it.last = (i == msg.size() - 1);
      byte_queue.push_back(it);
      queued_count++;
    end
  endtask

  task automatic queue_random_message();
    logic [7:0] msg[$];
    logic [7:0] hdr;
    logic [7:0] tl;
    logic [7:0] il;
    logic [31:0] pl;
    longint unsigned body;
    int unsigned roll, n_rec, flaw_rec, sel, pick;
    flaw_t flaw;
    logic stop;
    roll = $urandom_range(99);
    flaw = roll < 58 ? FLAW_NONE : roll < 66 ? FLAW_TRUNCATE : roll < 72 ? FLAW_EARLY_ME :
           roll < 77 ? FLAW_NO_ME : roll < 82 ? FLAW_BAD_MB : roll < 88 ? FLAW_MANY :
           roll < 94 ? FLAW_LIMIT : FLAW_NOISE;
    if (flaw == FLAW_NOISE) begin
      repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom));
    end else begin
      n_rec = (flaw == FLAW_MANY) ? $urandom_range(15, 17) : $urandom_range(1, 4);
      if (flaw == FLAW_EARLY_ME && n_rec == 1) n_rec = 2;
      flaw_rec = (flaw == FLAW_EARLY_ME) ? $urandom_range(0, n_rec - 2)
                                         : $urandom_range(0, n_rec - 1);
      stop = 1'b0;
      for (int r = 0; r < n_rec && !stop; r++) begin
        hdr = 8'($urandom);
        hdr[FLAG_MB_BIT] = (r == 0);
        hdr[FLAG_ME_BIT] = (r == n_rec - 1);
        if (flaw == FLAW_EARLY_ME && r == flaw_rec) hdr[FLAG_ME_BIT] = 1'b1;
        if (flaw == FLAW_NO_ME) hdr[FLAG_ME_BIT] = 1'b0;
        if (flaw == FLAW_BAD_MB && r == flaw_rec) hdr[FLAG_MB_BIT] = ~hdr[FLAG_MB_BIT];
        hdr[FLAG_SR_BIT] = ($urandom_range(3) != 0);
        if (flaw == FLAW_MANY) begin
          hdr[FLAG_IL_BIT] = 1'b0;
          tl = 8'd0;
          il = 8'd0;
          pl = ($urandom_range(3) == 0) ? 32'd1 : 32'd0;
        end else begin
          tl = 8'($urandom_range(0, 3));
          il = hdr[FLAG_IL_BIT] ? 8'($urandom_range(0, 3)) : 8'd0;
          pl = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
        end
        // push one length to or past its limit
        if (flaw == FLAW_LIMIT && r == flaw_rec) begin
          sel = $urandom_range(2);
          pick = $urandom_range(3);
          if (sel == 0) begin
            tl = pick == 0 ? 8'(MAX_TYPE_BYTES) : pick == 1 ? 8'(MAX_TYPE_BYTES + 1) : 8'hFF;
          end else if (sel == 1) begin
            hdr[FLAG_IL_BIT] = 1'b1;
            il = pick == 0 ? 8'(MAX_ID_BYTES) : pick == 1 ? 8'(MAX_ID_BYTES + 1) : 8'hFF;
          end else begin
            hdr[FLAG_SR_BIT] = 1'b0;
            pl = pick == 0 ? PAYLOAD_MAX : pick == 1 ? PAYLOAD_MAX + 1 :
                 pick == 2 ? 32'hFFFF_FFFF : $urandom;
          end
        end
        msg.push_back(hdr);
        msg.push_back(tl);
        if (hdr[FLAG_SR_BIT])
          msg.push_back(pl[7:0]);
        else begin
          msg.push_back(pl[31:24]);
          msg.push_back(pl[23:16]);
          msg.push_back(pl[15:8]);
          msg.push_back(pl[7:0]);
        end
        if (hdr[FLAG_IL_BIT]) msg.push_back(il);
        body = longint'(tl) + longint'(il) + longint'(pl);
        // end inside an oversized record rather than stream all of it
        if (body > 80) begin
          repeat ($urandom_range(1, 20)) msg.push_back(8'($urandom));
          stop = 1'b1;
        end else begin
          repeat (int'(body)) msg.push_back(8'($urandom));
        end
      end
      if (flaw == FLAW_TRUNCATE && msg.size() > 1)
        repeat ($urandom_range(1, msg.size() - 1)) void'(msg.pop_back());
    end
    queue_message(msg);
  endtask

  task automatic queue_random_bytes(input int unsigned count);
    int unsigned start;
    start = queued_count;
    while (queued_count - start < count) queue_random_message();
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (byte_queue.size() != 0 || in_valid || expected_tags.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Sender: offer the next item once the current one has gone
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || byte_taken) begin
      if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = byte_queue.pop_front();
        in_valid <= 1'b1;
        data_byte <= next_item.data;
        last_byte <= next_item.last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst)
      out_stall <= 1'b0;
    else
      out_stall <= long_hold || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) expected_tags.push_back(parse_byte(data_byte, last_byte));
      if (out_valid && !out_stall) begin
        if (expected_tags.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, byte %02h", field_byte));
        end else begin
          want_tag = expected_tags.pop_front();
          compare_field("field_byte", field_byte, want_tag.field_byte);
          compare_field("byte_kind", byte_kind, want_tag.byte_kind);
          compare_field("record_index", record_index, want_tag.record_index);
          compare_field("record_tnf", record_tnf, want_tag.record_tnf);
          compare_field("record_end", record_end, want_tag.record_end);
          compare_field("message_done", message_done, want_tag.message_done);
          compare_field("status", status, want_tag.status);
        end
      end
    end
  end

  // Hold the receiver off long enough for the block to back up its input
  initial begin
    wait (pressure_go);
    repeat (40) @(posedge clk);
    long_hold = 1'b1;
    repeat (250) @(posedge clk);
    long_hold = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    logic [7:0] msg[$];
    clear_parse();
    storage_limit = CAPACITY_RESET;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 8;
    recv_idle_pct = 55;
    apb_write(16'd2);
    msg = {8'hD1, 8'h01, 8'h01, 8'h54, 8'hFF};
    queue_message(msg);
    // first header lacks MB
    msg = {8'h00};
    queue_message(msg);
    msg = {8'hCF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h01, 8'hA5, 8'h3C};
    queue_message(msg);
    // record too big for storage, completed
    msg = {8'hD2, 8'h00, 8'h03, 8'h11, 8'h22, 8'h33};
    queue_message(msg);
    // type length over the limit
    msg = {8'hD1, 8'h21, 8'h00};
    queue_message(msg);
    wait_drained();

    apb_write(16'd0);
    queue_random_bytes(150);
    wait_drained();

    send_idle_pct = 55;
    recv_idle_pct = 8;
    apb_write(16'hFFFF);
    queue_random_bytes(150);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apb_write(16'($urandom_range(8, 64)));
    pressure_go = 1'b1;
    queue_random_bytes(150);
    wait_drained();

    apb_write(16'($urandom));
    queue_random_bytes(100);
    wait_drained();

    if (mismatches == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
